[hdl/plf_pkg.sv]
// Shared widths and the peer entry type for the peer learning fanout block.
`default_nettype none
package plf_pkg;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int DATA_W = ADDR_W + PORT_W;

    // Port in the upper bits, address in the lower bits, as on tdata.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
    } t_peer;
endpackage
`default_nettype wire

[hdl/peer_learning_fanout.sv]
// Learning flood forwarder: peer table in a single-port-read RAM, one beat per destination.
//
// Slave channel (i_s_axis_*): one beat per arriving packet, carrying the sender's
// address and port. Master channel (o_m_axis_*): one beat per destination, in
// table order, every stored peer except the sender; tlast marks the final one.
// A packet whose sender is the only stored peer, or that arrives at an empty
// table, produces no beats.
//
// Each packet takes a match pass over the stored peers (one RAM read per cycle,
// with a registered read port), an append step that stores an unknown sender
// while the table has room, and an emit pass that, while the receiver does not
// stall, reads one entry per cycle and issues at most one destination per cycle.
// The slave side is ready only between packets.
//
// Reset empties the table (peer count to zero) and drops any pending beat.
// When the receiver stalls, the output register holds its beat and the emit
// pass waits on it; the next packet may be accepted while the last beat of the
// previous one still waits.
`default_nettype none
module peer_learning_fanout #(
    parameter int MAX_PEERS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output      logic                       o_s_axis_tready,
    // [31:0] source_address, [47:32] source_port
    input  wire logic [plf_pkg::DATA_W-1:0] i_s_axis_tdata,
    output      logic                       o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // [31:0] dest_address, [47:32] dest_port
    output      logic [plf_pkg::DATA_W-1:0] o_m_axis_tdata,
    // last_dest
    output      logic                       o_m_axis_tlast
);
    import plf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PEERS + 1);
    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPEND,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_peer            r_src;
    t_peer            r_q;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_pend_idx;
    logic [CNT_W-1:0] r_match_idx;
    logic [CNT_W-1:0] r_last_idx;
    logic             r_pend;
    logic             r_known;
    logic             r_stored;
    logic             r_ovalid;
    logic             r_olast;
    t_peer            r_odata;

    t_peer            mem [MAX_PEERS];

    logic             rd_more;
    logic             wr_en;
    logic             skip;
    logic             out_free;
    logic             resolve;
    logic             emit_go;
    logic             rd_en;
    logic             load_out;
    logic [CNT_W-1:0] n_total;
    logic             n_hit_last;

    always_comb begin
        rd_more    = (r_rd_idx < r_total);
        wr_en      = (r_state == S_APPEND) && !r_known && (r_total < CNT_W'(MAX_PEERS));
        n_total    = wr_en ? CNT_W'(r_total + 1'b1) : r_total;
        n_hit_last = wr_en || (r_known && (r_match_idx == CNT_W'(n_total - 1'b1)));
        skip       = r_stored && (r_pend_idx == r_match_idx);
        out_free   = !r_ovalid || i_m_axis_tready;
        resolve    = r_pend && (skip || out_free);
        emit_go    = (!r_pend || resolve) && rd_more;
        rd_en      = ((r_state == S_MATCH) && rd_more) || ((r_state == S_EMIT) && emit_go);
        load_out   = (r_state == S_EMIT) && r_pend && !skip && out_free;
    end

    // Peer table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_total[IDX_W-1:0]] <= r_src;
        end
        if (rd_en) begin
            r_q <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_known  <= 1'b0;
            r_stored <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_src    <= t_peer'(i_s_axis_tdata);
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        r_known  <= 1'b0;
                        r_state  <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    // compare the entry read last cycle while issuing the next read
                    if (r_pend && (r_q == r_src)) begin
                        r_known     <= 1'b1;
                        r_match_idx <= r_pend_idx;
                    end
                    if (rd_more) begin
                        r_rd_idx   <= CNT_W'(r_rd_idx + 1'b1);
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_APPEND;
                        end
                    end
                end
                S_APPEND: begin
                    r_total  <= n_total;
                    r_stored <= r_known || wr_en;
                    if (wr_en) begin
                        r_match_idx <= r_total;
                    end
                    r_last_idx <= n_hit_last ? CNT_W'(n_total - 2'd2)
                                             : CNT_W'(n_total - 1'b1);
                    r_rd_idx   <= '0;
                    r_pend     <= 1'b0;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_odata <= r_q;
                        r_olast <= (r_pend_idx == r_last_idx);
                    end
                    if (emit_go) begin
                        r_rd_idx   <= CNT_W'(r_rd_idx + 1'b1);
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx;
                    end else if (resolve) begin
                        r_pend <= 1'b0;
                    end
                    if (!emit_go && (!r_pend || resolve)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

[tb/sv/tb_peer_learning_fanout.sv]
// Self-checking testbench for the peer learning fanout block.
`timescale 1ns / 1ps
`default_nettype none
module tb_peer_learning_fanout;
    import plf_pkg::*;

    localparam int PEER_DEPTH = 16;
    localparam int DRAIN_CYCLES = 2 * PEER_DEPTH + 8;
    localparam int RANDOM_PER_PHASE = 33;

    typedef struct packed {
        t_peer peer;
        logic  last;
    } t_dest;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              s_valid = 1'b0;
    t_peer             s_item = '0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_data;
    logic              m_last;

    // Packets waiting to be driven, and the destinations they must produce.
    t_peer pkt_q[$];
    t_dest dest_q[$];

    // Learned peer table as the block should hold it.
    t_peer       learned[PEER_DEPTH];
    int unsigned learned_total = 0;

    int unsigned send_gap_pct = 13;
    int unsigned recv_stall_pct = 52;

    int unsigned pkts_queued = 0;
    int unsigned pkts_accepted = 0;
    int unsigned beats_checked = 0;
    int unsigned silent_pkts = 0;
    int unsigned unstored_pkts = 0;
    int unsigned known_pkts = 0;
    int unsigned errors = 0;

    peer_learning_fanout #(
        .MAX_PEERS(PEER_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_item),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Learn the sender if it is new and there is room, then fan out to every other peer.
    task automatic learn_and_fan_out(input t_peer src);
        bit known;
        int last_idx;
        known = 1'b0;
        last_idx = -1;
        for (int i = 0; i < learned_total; i++) begin
            if (learned[i] == src) known = 1'b1;
        end
        if (known) begin
            known_pkts++;
        end else if (learned_total < PEER_DEPTH) begin
            learned[learned_total] = src;
            learned_total++;
        end else begin
            unstored_pkts++;
        end
        for (int i = 0; i < learned_total; i++) begin
            if (learned[i] != src) last_idx = i;
        end
        if (last_idx < 0) silent_pkts++;
        for (int i = 0; i < learned_total; i++) begin
            if (learned[i] != src) dest_q.push_back('{peer: learned[i], last: (i == last_idx)});
        end
    endtask

    function automatic t_peer random_packet();
        t_peer p;
        int unsigned pick;
        int unsigned bit_idx;
        pick = $urandom_range(99);
        p.addr = $urandom;
        p.port = PORT_W'($urandom);
        if (learned_total == 0) return p;
        if (pick < 55) begin
            p = learned[$urandom_range(learned_total - 1)];
        end else if (pick < 75) begin
            // Near miss: one field of a stored peer, the other off by a bit or replaced.
            p = learned[$urandom_range(learned_total - 1)];
            bit_idx = $urandom_range(DATA_W - 1);
            case ($urandom_range(2))
                0: p[bit_idx] = ~p[bit_idx];
                1: p.addr = $urandom;
                default: p.port = PORT_W'($urandom);
            endcase
        end else if (pick < 85) begin
            case ($urandom_range(2))
                0: p.addr = '0;
                1: p.addr = '1;
                default: ;
            endcase
            case ($urandom_range(2))
                0: p.port = '0;
                1: p.port = '1;
                default: ;
            endcase
        end
        return p;
    endfunction

    task automatic queue_packet(input t_peer p);
        pkt_q.push_back(p);
        pkts_queued++;
    endtask

    task automatic wait_all_accepted();
        while (pkts_accepted != pkts_queued) @(posedge i_clk);
    endtask

    task automatic wait_all_delivered();
        wait_all_accepted();
        while (dest_q.size() != 0) @(posedge i_clk);
    endtask

    // Sender: predict on each accepted beat, then offer the next packet or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                learn_and_fan_out(s_item);
                pkts_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pkt_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_valid <= 1'b1;
                    s_item <= pkt_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each delivered beat against the oldest expected destination.
    always @(posedge i_clk) begin
        t_dest want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (dest_q.size() == 0) begin
                    $error("unexpected beat: addr %h port %h last %b",
                           m_data[ADDR_W-1:0], m_data[DATA_W-1:ADDR_W], m_last);
                    errors++;
                end else begin
                    want = dest_q.pop_front();
                    beats_checked++;
                    if (m_data[ADDR_W-1:0] !== want.peer.addr) begin
                        $error("dest_address: expected %h, got %h",
                               want.peer.addr, m_data[ADDR_W-1:0]);
                        errors++;
                    end
                    if (m_data[DATA_W-1:ADDR_W] !== want.peer.port) begin
                        $error("dest_port: expected %h, got %h",
                               want.peer.port, m_data[DATA_W-1:ADDR_W]);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last_dest: expected %b, got %b", want.last, m_last);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        t_peer p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, lone sender repeated, then the four corner senders.
        queue_packet('{port: 16'h0000, addr: 32'h0000_0000});
        queue_packet('{port: 16'h0000, addr: 32'h0000_0000});
        queue_packet('{port: 16'hffff, addr: 32'hffff_ffff});
        queue_packet('{port: 16'hffff, addr: 32'h0000_0000});
        queue_packet('{port: 16'h0000, addr: 32'hffff_ffff});
        queue_packet('{port: 16'h0000, addr: 32'h0000_0000});
        // Fill the table with alternating-bit patterns and random peers.
        queue_packet('{port: 16'haaaa, addr: 32'h5555_5555});
        queue_packet('{port: 16'h5555, addr: 32'haaaa_aaaa});
        for (int i = 0; i < PEER_DEPTH - 6; i++) begin
            p.addr = {i[7:0], 24'(($urandom))};
            p.port = PORT_W'($urandom);
            queue_packet(p);
        end
        // Full table: a stranger is served but not stored, then two known senders and the stranger again.
        queue_packet('{port: 16'h9abc, addr: 32'h1234_5678});
        queue_packet('{port: 16'h0000, addr: 32'h0000_0000});
        queue_packet('{port: 16'hffff, addr: 32'hffff_ffff});
        queue_packet('{port: 16'h9abc, addr: 32'h1234_5678});

        // Hold the sender until every destination so far has come back.
        wait_all_delivered();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 13;
                    recv_stall_pct = 52;
                end
                1: begin
                    send_gap_pct = 52;
                    recv_stall_pct = 13;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_packet(random_packet());
            wait_all_accepted();
        end

        wait_all_delivered();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d packets (%0d known, %0d unstored strangers, %0d with no beats)",
                 pkts_accepted, known_pkts, unstored_pkts, silent_pkts);
        $display("checked %0d destination beats against a %0d-entry peer table",
                 beats_checked, learned_total);
        if (errors == 0 && dest_q.size() == 0) begin
            $display("peer_learning_fanout regression: pass");
        end else begin
            $display("peer_learning_fanout regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("peer_learning_fanout regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/plf_pkg.sv
hdl/peer_learning_fanout.sv
tb/sv/tb_peer_learning_fanout.sv
